// ===== rtl/wmsc_pkg.sv =====
// Shared types, codes and digit helpers for the watch mode and set controller.
package wmsc_pkg;

  // Display modes
  typedef enum logic [3:0] {
    MODE_SHOW_TIME   = 4'd0,
    MODE_SHOW_DATE   = 4'd1,
    MODE_SHOW_YEAR   = 4'd2,
    MODE_SHOW_BAT    = 4'd3,
    MODE_SHOW_BRIGHT = 4'd4,
    MODE_EDIT_HOURS  = 4'd5,
    MODE_EDIT_MINS   = 4'd6,
    MODE_EDIT_DAY    = 4'd7,
    MODE_EDIT_MONTH  = 4'd8,
    MODE_EDIT_YEAR   = 4'd9,
    MODE_EDIT_BRIGHT = 4'd10
  } mode_t;

  // Button events
  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_UP        = 3'd1;
  localparam logic [2:0] OP_DOWN      = 3'd2;
  localparam logic [2:0] OP_BOTH_DOWN = 3'd3;
  localparam logic [2:0] OP_BOTH_UP   = 3'd4;

  // Digit and decimal point codes
  localparam logic [3:0] BLANK = 4'd10;
  localparam logic [3:0] PT1   = 4'b0001;
  localparam logic [3:0] PT2   = 4'b0010;
  localparam logic [3:0] PT3   = 4'b0100;
  localparam logic [3:0] PT4   = 4'b1000;

  // Reset values and limits
  localparam logic [4:0] HOURS_MAX   = 5'd23;
  localparam logic [5:0] MINUTES_MAX = 6'd59;
  localparam logic [4:0] DAY_MAX     = 5'd31;
  localparam logic [3:0] MONTH_MAX   = 4'd12;
  localparam logic [6:0] YEAR_MAX    = 7'd99;
  localparam logic [6:0] BRIGHT_MAX  = 7'd99;
  localparam logic [6:0] BRIGHT_MIN  = 7'd1;
  localparam logic [6:0] BRIGHT_INIT = 7'd50;

  typedef struct packed {
    mode_t      mode;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
    logic [6:0] brightness;
  } wmsc_state_t;

  typedef struct packed {
    logic       blink_phase;
    logic [2:0] opcode;
    logic [5:0] rtc_hour_bcd;
    logic [6:0] rtc_minute_bcd;
    logic [5:0] rtc_day_bcd;
    logic [4:0] rtc_month_bcd;
    logic [7:0] rtc_year_bcd;
    logic [6:0] battery_percent;
  } wmsc_item_t;

  typedef struct packed {
    logic [15:0] display_digits;
    logic [3:0]  decimal_points;
    logic        write_time;
    logic        write_date;
    logic [4:0]  set_hours;
    logic [5:0]  set_minutes;
    logic [4:0]  set_day;
    logic [3:0]  set_month;
    logic [6:0]  set_year;
    logic [6:0]  brightness_level;
  } wmsc_result_t;

  // Split a 7-bit value into (value/10)%10 and value%10 via reciprocal multiply
  function automatic logic [7:0] dec2(logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [3:0]  tens;
    logic [6:0]  rem;
    prod = 15'(v) * 15'd205;
    q    = prod[14:11];
    tens = (q >= 4'd10) ? q - 4'd10 : q;
    rem  = v - 7'(q) * 7'd10;
    return {tens, rem[3:0]};
  endfunction

  // Two BCD digits to binary, unclamped
  function automatic logic [7:0] bcd_val(logic [3:0] tens, logic [3:0] units);
    return 8'(tens) * 8'd10 + 8'(units);
  endfunction

  // Wrapping increment or decrement between lo and hi
  function automatic logic [6:0] wrap_step(logic [6:0] v, logic [2:0] op,
                                           logic [6:0] lo, logic [6:0] hi);
    logic [6:0] r;
    r = v;
    if (op == OP_UP) begin
      r = (v >= hi) ? lo : v + 7'd1;
    end else if (op == OP_DOWN) begin
      r = (v <= lo) ? hi : v - 7'd1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/wmsc_step.sv =====
// Combinational step: renders one display word and computes the next mode and edit values.
module wmsc_step (
  input  wmsc_pkg::wmsc_state_t  st,
  input  wmsc_pkg::wmsc_item_t   item,
  output wmsc_pkg::wmsc_state_t  st_next,
  output wmsc_pkg::wmsc_result_t res
);

  logic [7:0] hv, mv, dv, mov, yv;
  logic [4:0] ld_hours;
  logic [5:0] ld_minutes;
  logic [4:0] ld_day;
  logic [3:0] ld_month;
  logic [6:0] ld_year;
  logic [2:0] op;

  assign op = item.opcode;

  // Convert and clamp the RTC fields for loading into the edit registers
  always_comb begin
    hv  = wmsc_pkg::bcd_val({2'b00, item.rtc_hour_bcd[5:4]}, item.rtc_hour_bcd[3:0]);
    mv  = wmsc_pkg::bcd_val({1'b0, item.rtc_minute_bcd[6:4]}, item.rtc_minute_bcd[3:0]);
    dv  = wmsc_pkg::bcd_val({2'b00, item.rtc_day_bcd[5:4]}, item.rtc_day_bcd[3:0]);
    mov = wmsc_pkg::bcd_val({3'b000, item.rtc_month_bcd[4]}, item.rtc_month_bcd[3:0]);
    yv  = wmsc_pkg::bcd_val(item.rtc_year_bcd[7:4], item.rtc_year_bcd[3:0]);
    ld_hours   = (hv > 8'(wmsc_pkg::HOURS_MAX)) ? wmsc_pkg::HOURS_MAX : hv[4:0];
    ld_minutes = (mv > 8'(wmsc_pkg::MINUTES_MAX)) ? wmsc_pkg::MINUTES_MAX : mv[5:0];
    if (dv == 8'd0) begin
      ld_day = 5'd1;
    end else if (dv > 8'(wmsc_pkg::DAY_MAX)) begin
      ld_day = wmsc_pkg::DAY_MAX;
    end else begin
      ld_day = dv[4:0];
    end
    if (mov == 8'd0) begin
      ld_month = 4'd1;
    end else if (mov > 8'(wmsc_pkg::MONTH_MAX)) begin
      ld_month = wmsc_pkg::MONTH_MAX;
    end else begin
      ld_month = mov[3:0];
    end
    ld_year = (yv > 8'(wmsc_pkg::YEAR_MAX)) ? wmsc_pkg::YEAR_MAX : yv[6:0];
  end

  // Render with the current mode, then act on the button word
  always_comb begin
    st_next = st;
    res.display_digits = '0;
    res.decimal_points = '0;
    res.write_time     = 1'b0;
    res.write_date     = 1'b0;
    unique case (st.mode)
      wmsc_pkg::MODE_SHOW_DATE: begin
        res.display_digits = {2'b00, item.rtc_day_bcd[5:4], item.rtc_day_bcd[3:0],
                              3'b000, item.rtc_month_bcd[4], item.rtc_month_bcd[3:0]};
        res.decimal_points = wmsc_pkg::PT2;
        unique case (op)
          wmsc_pkg::OP_UP:   st_next.mode = wmsc_pkg::MODE_SHOW_YEAR;
          wmsc_pkg::OP_DOWN: st_next.mode = wmsc_pkg::MODE_SHOW_TIME;
          wmsc_pkg::OP_BOTH_DOWN: begin
            st_next.mode  = wmsc_pkg::MODE_EDIT_DAY;
            st_next.day   = ld_day;
            st_next.month = ld_month;
            st_next.year  = ld_year;
          end
          wmsc_pkg::OP_BOTH_UP: begin
            st_next.mode  = wmsc_pkg::MODE_EDIT_MONTH;
            st_next.day   = ld_day;
            st_next.month = ld_month;
            st_next.year  = ld_year;
          end
          default: ;
        endcase
      end
      wmsc_pkg::MODE_SHOW_YEAR: begin
        res.display_digits = {4'd2, 4'd0, item.rtc_year_bcd[7:4], item.rtc_year_bcd[3:0]};
        if (op == wmsc_pkg::OP_DOWN) begin
          st_next.mode = wmsc_pkg::MODE_SHOW_DATE;
        end else if (op == wmsc_pkg::OP_BOTH_DOWN || op == wmsc_pkg::OP_BOTH_UP) begin
          st_next.mode  = wmsc_pkg::MODE_EDIT_YEAR;
          st_next.day   = ld_day;
          st_next.month = ld_month;
          st_next.year  = ld_year;
        end
      end
      wmsc_pkg::MODE_SHOW_BAT: begin
        res.display_digits = {wmsc_pkg::BLANK, wmsc_pkg::dec2(item.battery_percent),
                              wmsc_pkg::BLANK};
        if (op == wmsc_pkg::OP_UP) begin
          st_next.mode = wmsc_pkg::MODE_SHOW_TIME;
        end else if (op == wmsc_pkg::OP_DOWN) begin
          st_next.mode = wmsc_pkg::MODE_SHOW_BRIGHT;
        end
      end
      wmsc_pkg::MODE_SHOW_BRIGHT: begin
        res.display_digits = {wmsc_pkg::BLANK, wmsc_pkg::BLANK,
                              wmsc_pkg::dec2(st.brightness)};
        if (op == wmsc_pkg::OP_UP) begin
          st_next.mode = wmsc_pkg::MODE_SHOW_BAT;
        end else if (op == wmsc_pkg::OP_BOTH_DOWN) begin
          st_next.mode = wmsc_pkg::MODE_EDIT_BRIGHT;
        end
      end
      wmsc_pkg::MODE_EDIT_HOURS: begin
        st_next.hours = 5'(wmsc_pkg::wrap_step(7'(st.hours), op, 7'd0,
                                               7'(wmsc_pkg::HOURS_MAX)));
        if (op == wmsc_pkg::OP_BOTH_DOWN) begin
          st_next.mode = wmsc_pkg::MODE_EDIT_MINS;
        end else if (op == wmsc_pkg::OP_BOTH_UP) begin
          st_next.mode   = wmsc_pkg::MODE_SHOW_TIME;
          res.write_time = 1'b1;
        end
        res.display_digits = {wmsc_pkg::dec2(7'(st_next.hours)),
                              wmsc_pkg::dec2(7'(st_next.minutes))};
        res.decimal_points = wmsc_pkg::PT1 | wmsc_pkg::PT2;
      end
      wmsc_pkg::MODE_EDIT_MINS: begin
        st_next.minutes = 6'(wmsc_pkg::wrap_step(7'(st.minutes), op, 7'd0,
                                                 7'(wmsc_pkg::MINUTES_MAX)));
        if (op == wmsc_pkg::OP_BOTH_DOWN) begin
          st_next.mode   = wmsc_pkg::MODE_SHOW_TIME;
          res.write_time = 1'b1;
        end else if (op == wmsc_pkg::OP_BOTH_UP) begin
          st_next.mode = wmsc_pkg::MODE_EDIT_HOURS;
        end
        res.display_digits = {wmsc_pkg::dec2(7'(st_next.hours)),
                              wmsc_pkg::dec2(7'(st_next.minutes))};
        res.decimal_points = wmsc_pkg::PT3 | wmsc_pkg::PT4;
      end
      wmsc_pkg::MODE_EDIT_DAY: begin
        st_next.day = 5'(wmsc_pkg::wrap_step(7'(st.day), op, 7'd1,
                                             7'(wmsc_pkg::DAY_MAX)));
        if (op == wmsc_pkg::OP_BOTH_DOWN) begin
          st_next.mode = wmsc_pkg::MODE_EDIT_MONTH;
        end else if (op == wmsc_pkg::OP_BOTH_UP) begin
          st_next.mode   = wmsc_pkg::MODE_SHOW_DATE;
          res.write_date = 1'b1;
        end
        res.display_digits = {wmsc_pkg::dec2(7'(st_next.day)),
                              wmsc_pkg::dec2(7'(st_next.month))};
        res.decimal_points = wmsc_pkg::PT1 | wmsc_pkg::PT2;
      end
      wmsc_pkg::MODE_EDIT_MONTH: begin
        st_next.month = 4'(wmsc_pkg::wrap_step(7'(st.month), op, 7'd1,
                                               7'(wmsc_pkg::MONTH_MAX)));
        if (op == wmsc_pkg::OP_BOTH_DOWN) begin
          st_next.mode   = wmsc_pkg::MODE_SHOW_DATE;
          res.write_date = 1'b1;
        end else if (op == wmsc_pkg::OP_BOTH_UP) begin
          st_next.mode = wmsc_pkg::MODE_EDIT_DAY;
        end
        res.display_digits = {wmsc_pkg::dec2(7'(st_next.day)),
                              wmsc_pkg::dec2(7'(st_next.month))};
        res.decimal_points = wmsc_pkg::PT3 | wmsc_pkg::PT4;
      end
      wmsc_pkg::MODE_EDIT_YEAR: begin
        st_next.year = wmsc_pkg::wrap_step(st.year, op, 7'd0, wmsc_pkg::YEAR_MAX);
        if (op == wmsc_pkg::OP_BOTH_DOWN || op == wmsc_pkg::OP_BOTH_UP) begin
          st_next.mode   = wmsc_pkg::MODE_SHOW_YEAR;
          res.write_date = 1'b1;
        end
        res.display_digits = {4'd2, 4'd0, wmsc_pkg::dec2(st_next.year)};
        res.decimal_points = wmsc_pkg::PT3 | wmsc_pkg::PT4;
      end
      wmsc_pkg::MODE_EDIT_BRIGHT: begin
        // Saturate instead of wrapping
        if (op == wmsc_pkg::OP_UP) begin
          if (st.brightness < wmsc_pkg::BRIGHT_MAX) begin
            st_next.brightness = st.brightness + 7'd1;
          end
        end else if (op == wmsc_pkg::OP_DOWN) begin
          if (st.brightness > wmsc_pkg::BRIGHT_MIN) begin
            st_next.brightness = st.brightness - 7'd1;
          end
        end else if (op == wmsc_pkg::OP_BOTH_DOWN || op == wmsc_pkg::OP_BOTH_UP) begin
          st_next.mode = wmsc_pkg::MODE_SHOW_BRIGHT;
        end
        res.display_digits = {wmsc_pkg::BLANK, wmsc_pkg::BLANK,
                              wmsc_pkg::dec2(st_next.brightness)};
        res.decimal_points = wmsc_pkg::PT3 | wmsc_pkg::PT4;
      end
      default: begin
        // Show time; unused mode codes fall back here as well
        res.display_digits = {2'b00, item.rtc_hour_bcd[5:4], item.rtc_hour_bcd[3:0],
                              1'b0, item.rtc_minute_bcd[6:4], item.rtc_minute_bcd[3:0]};
        res.decimal_points = item.blink_phase ? wmsc_pkg::PT2 : 4'b0000;
        unique case (op)
          wmsc_pkg::OP_UP:   st_next.mode = wmsc_pkg::MODE_SHOW_DATE;
          wmsc_pkg::OP_DOWN: st_next.mode = wmsc_pkg::MODE_SHOW_BAT;
          wmsc_pkg::OP_BOTH_DOWN: begin
            st_next.mode    = wmsc_pkg::MODE_EDIT_HOURS;
            st_next.hours   = ld_hours;
            st_next.minutes = ld_minutes;
          end
          wmsc_pkg::OP_BOTH_UP: begin
            st_next.mode    = wmsc_pkg::MODE_EDIT_MINS;
            st_next.hours   = ld_hours;
            st_next.minutes = ld_minutes;
          end
          default: st_next.mode = wmsc_pkg::MODE_SHOW_TIME;
        endcase
      end
    endcase
    res.set_hours        = st_next.hours;
    res.set_minutes      = st_next.minutes;
    res.set_day          = st_next.day;
    res.set_month        = st_next.month;
    res.set_year         = st_next.year;
    res.brightness_level = st_next.brightness;
  end

endmodule

// ===== rtl/watch_mode_and_set_controller.sv =====
// Top level of the watch mode and set controller: input register, step logic, result register.
// A word accepted into the input register passes through the step logic into the result register.
// Throughput: one word per cycle while the output is not stalled; the mode and edit registers
// update in the same cycle the step logic consumes a word, so the next word sees them at once.
// Output stall propagates to in_stall only when both the input and result registers hold words.
// Reset (synchronous, active high): mode shows time, hours/minutes/year 0, day/month 1,
// brightness 50, both register stages empty.
module watch_mode_and_set_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        blink_phase,
  input  logic [2:0]  opcode,
  input  logic [5:0]  rtc_hour_bcd,
  input  logic [6:0]  rtc_minute_bcd,
  input  logic [5:0]  rtc_day_bcd,
  input  logic [4:0]  rtc_month_bcd,
  input  logic [7:0]  rtc_year_bcd,
  input  logic [6:0]  battery_percent,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] display_digits,
  output logic [3:0]  decimal_points,
  output logic        write_time,
  output logic        write_date,
  output logic [4:0]  set_hours,
  output logic [5:0]  set_minutes,
  output logic [4:0]  set_day,
  output logic [3:0]  set_month,
  output logic [6:0]  set_year,
  output logic [6:0]  brightness_level
);

  logic                   item_valid;
  wmsc_pkg::wmsc_item_t   item;
  wmsc_pkg::wmsc_state_t  st;
  wmsc_pkg::wmsc_state_t  st_next;
  wmsc_pkg::wmsc_result_t res_next;
  wmsc_pkg::wmsc_result_t res;
  logic                   out_ready;
  logic                   step_fire;

  // Handshake: the result register frees up when empty or being taken
  assign out_ready = !out_valid || !out_stall;
  assign step_fire = item_valid && out_ready;
  assign in_stall  = item_valid && !out_ready;

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.blink_phase     <= blink_phase;
      item.opcode          <= opcode;
      item.rtc_hour_bcd    <= rtc_hour_bcd;
      item.rtc_minute_bcd  <= rtc_minute_bcd;
      item.rtc_day_bcd     <= rtc_day_bcd;
      item.rtc_month_bcd   <= rtc_month_bcd;
      item.rtc_year_bcd    <= rtc_year_bcd;
      item.battery_percent <= battery_percent;
    end
  end

  wmsc_step u_step (
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .res     (res_next)
  );

  // Advance mode and edit values once per consumed word
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode       <= wmsc_pkg::MODE_SHOW_TIME;
      st.hours      <= 5'd0;
      st.minutes    <= 6'd0;
      st.day        <= 5'd1;
      st.month      <= 4'd1;
      st.year       <= 7'd0;
      st.brightness <= wmsc_pkg::BRIGHT_INIT;
    end else if (step_fire) begin
      st <= st_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      res <= res_next;
    end
  end

  assign display_digits   = res.display_digits;
  assign decimal_points   = res.decimal_points;
  assign write_time       = res.write_time;
  assign write_date       = res.write_date;
  assign set_hours        = res.set_hours;
  assign set_minutes      = res.set_minutes;
  assign set_day          = res.set_day;
  assign set_month        = res.set_month;
  assign set_year         = res.set_year;
  assign brightness_level = res.brightness_level;

  // Time and date writes never pulse together
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(write_time && write_date))
    else $error("time and date write pulsed together");

  // Brightness stays inside its saturation range
  assert property (@(posedge clk) disable iff (rst)
    (st.brightness >= wmsc_pkg::BRIGHT_MIN) && (st.brightness <= wmsc_pkg::BRIGHT_MAX))
    else $error("brightness out of range");

  // Mode only moves when a word is consumed
  assert property (@(posedge clk) disable iff (rst)
    !step_fire |=> $stable(st.mode))
    else $error("mode changed without a word");

  // A time write leaves the block showing time
  assert property (@(posedge clk) disable iff (rst)
    (step_fire && res_next.write_time) |=> (st.mode == wmsc_pkg::MODE_SHOW_TIME))
    else $error("time write did not return to time display");

endmodule

// ===== tb/tb_watch_mode_and_set_controller.sv =====
// Self-checking testbench for the watch mode and set controller: directed and random ticks.
module tb_watch_mode_and_set_controller;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_TICKS = 650;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  // Button codes the block treats as no event
  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  // Watch state mirror: predicts each result word and checks the words that come out
  class watch_scoreboard;
    wmsc_pkg::mode_t        cur_mode;
    logic [4:0]             hours;
    logic [5:0]             minutes;
    logic [4:0]             day;
    logic [3:0]             month;
    logic [6:0]             year;
    logic [6:0]             bright;
    wmsc_pkg::wmsc_result_t expected_q[$];
    int                     errors;

    function new();
      cur_mode = wmsc_pkg::MODE_SHOW_TIME;
      hours    = '0;
      minutes  = '0;
      day      = 5'd1;
      month    = 4'd1;
      year     = '0;
      bright   = wmsc_pkg::BRIGHT_INIT;
      errors   = 0;
    endfunction

    function int bcd_clamp(logic [3:0] tens, logic [3:0] units, int lo, int hi);
      int v;
      v = tens * 10 + units;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
    endfunction

    function int wrap_edit(int v, logic [2:0] op, int lo, int hi);
      if (op == wmsc_pkg::OP_UP) return (v >= hi) ? lo : v + 1;
      if (op == wmsc_pkg::OP_DOWN) return (v <= lo) ? hi : v - 1;
      return v;
    endfunction

    function logic [15:0] digits4(int a, int b, int c, int d);
      return {4'(a), 4'(b), 4'(c), 4'(d)};
    endfunction

    function logic [15:0] two_num(int a, int b);
      return digits4((a / 10) % 10, a % 10, (b / 10) % 10, b % 10);
    endfunction

    function void fetch_time(wmsc_pkg::wmsc_item_t t);
      hours   = 5'(bcd_clamp(4'(t.rtc_hour_bcd[5:4]), t.rtc_hour_bcd[3:0], 0,
                             wmsc_pkg::HOURS_MAX));
      minutes = 6'(bcd_clamp(4'(t.rtc_minute_bcd[6:4]), t.rtc_minute_bcd[3:0], 0,
                             wmsc_pkg::MINUTES_MAX));
    endfunction

    function void fetch_date(wmsc_pkg::wmsc_item_t t);
      day   = 5'(bcd_clamp(4'(t.rtc_day_bcd[5:4]), t.rtc_day_bcd[3:0], 1,
                           wmsc_pkg::DAY_MAX));
      month = 4'(bcd_clamp(4'(t.rtc_month_bcd[4]), t.rtc_month_bcd[3:0], 1,
                           wmsc_pkg::MONTH_MAX));
      year  = 7'(bcd_clamp(t.rtc_year_bcd[7:4], t.rtc_year_bcd[3:0], 0,
                           wmsc_pkg::YEAR_MAX));
    endfunction

    // Render with the mode held before the tick, then act on the button
    function void note_tick(wmsc_pkg::wmsc_item_t t);
      wmsc_pkg::wmsc_result_t r;
      logic [2:0]             op;
      op = t.opcode;
      r  = '0;
      case (cur_mode)
        wmsc_pkg::MODE_SHOW_DATE: begin
          r.display_digits = digits4(t.rtc_day_bcd[5:4], t.rtc_day_bcd[3:0],
                                     t.rtc_month_bcd[4], t.rtc_month_bcd[3:0]);
          r.decimal_points = wmsc_pkg::PT2;
          if (op == wmsc_pkg::OP_UP) cur_mode = wmsc_pkg::MODE_SHOW_YEAR;
          else if (op == wmsc_pkg::OP_DOWN) cur_mode = wmsc_pkg::MODE_SHOW_TIME;
          else if (op == wmsc_pkg::OP_BOTH_DOWN) begin
            cur_mode = wmsc_pkg::MODE_EDIT_DAY;
            fetch_date(t);
          end else if (op == wmsc_pkg::OP_BOTH_UP) begin
            cur_mode = wmsc_pkg::MODE_EDIT_MONTH;
            fetch_date(t);
          end
        end
        wmsc_pkg::MODE_SHOW_YEAR: begin
          r.display_digits = digits4(2, 0, t.rtc_year_bcd[7:4], t.rtc_year_bcd[3:0]);
          if (op == wmsc_pkg::OP_DOWN) cur_mode = wmsc_pkg::MODE_SHOW_DATE;
          else if (op == wmsc_pkg::OP_BOTH_DOWN || op == wmsc_pkg::OP_BOTH_UP) begin
            cur_mode = wmsc_pkg::MODE_EDIT_YEAR;
            fetch_date(t);
          end
        end
        wmsc_pkg::MODE_SHOW_BAT: begin
          r.display_digits = digits4(wmsc_pkg::BLANK, (t.battery_percent / 10) % 10,
                                     t.battery_percent % 10, wmsc_pkg::BLANK);
          if (op == wmsc_pkg::OP_UP) cur_mode = wmsc_pkg::MODE_SHOW_TIME;
          else if (op == wmsc_pkg::OP_DOWN) cur_mode = wmsc_pkg::MODE_SHOW_BRIGHT;
        end
        wmsc_pkg::MODE_SHOW_BRIGHT: begin
          r.display_digits = digits4(wmsc_pkg::BLANK, wmsc_pkg::BLANK, (bright / 10) % 10,
                                     bright % 10);
          if (op == wmsc_pkg::OP_UP) cur_mode = wmsc_pkg::MODE_SHOW_BAT;
          else if (op == wmsc_pkg::OP_BOTH_DOWN) cur_mode = wmsc_pkg::MODE_EDIT_BRIGHT;
        end
        wmsc_pkg::MODE_EDIT_HOURS: begin
          hours = 5'(wrap_edit(hours, op, 0, wmsc_pkg::HOURS_MAX));
          if (op == wmsc_pkg::OP_BOTH_DOWN) cur_mode = wmsc_pkg::MODE_EDIT_MINS;
          else if (op == wmsc_pkg::OP_BOTH_UP) begin
            cur_mode     = wmsc_pkg::MODE_SHOW_TIME;
            r.write_time = 1'b1;
          end
          r.display_digits = two_num(hours, minutes);
          r.decimal_points = wmsc_pkg::PT1 | wmsc_pkg::PT2;
        end
        wmsc_pkg::MODE_EDIT_MINS: begin
          minutes = 6'(wrap_edit(minutes, op, 0, wmsc_pkg::MINUTES_MAX));
          if (op == wmsc_pkg::OP_BOTH_DOWN) begin
            cur_mode     = wmsc_pkg::MODE_SHOW_TIME;
            r.write_time = 1'b1;
          end else if (op == wmsc_pkg::OP_BOTH_UP) cur_mode = wmsc_pkg::MODE_EDIT_HOURS;
          r.display_digits = two_num(hours, minutes);
          r.decimal_points = wmsc_pkg::PT3 | wmsc_pkg::PT4;
        end
        wmsc_pkg::MODE_EDIT_DAY: begin
          day = 5'(wrap_edit(day, op, 1, wmsc_pkg::DAY_MAX));
          if (op == wmsc_pkg::OP_BOTH_DOWN) cur_mode = wmsc_pkg::MODE_EDIT_MONTH;
          else if (op == wmsc_pkg::OP_BOTH_UP) begin
            cur_mode     = wmsc_pkg::MODE_SHOW_DATE;
            r.write_date = 1'b1;
          end
          r.display_digits = two_num(day, month);
          r.decimal_points = wmsc_pkg::PT1 | wmsc_pkg::PT2;
        end
        wmsc_pkg::MODE_EDIT_MONTH: begin
          month = 4'(wrap_edit(month, op, 1, wmsc_pkg::MONTH_MAX));
          if (op == wmsc_pkg::OP_BOTH_DOWN) begin
            cur_mode     = wmsc_pkg::MODE_SHOW_DATE;
            r.write_date = 1'b1;
          end else if (op == wmsc_pkg::OP_BOTH_UP) cur_mode = wmsc_pkg::MODE_EDIT_DAY;
          r.display_digits = two_num(day, month);
          r.decimal_points = wmsc_pkg::PT3 | wmsc_pkg::PT4;
        end
        wmsc_pkg::MODE_EDIT_YEAR: begin
          year = 7'(wrap_edit(year, op, 0, wmsc_pkg::YEAR_MAX));
          if (op == wmsc_pkg::OP_BOTH_DOWN || op == wmsc_pkg::OP_BOTH_UP) begin
            cur_mode     = wmsc_pkg::MODE_SHOW_YEAR;
            r.write_date = 1'b1;
          end
          r.display_digits = digits4(2, 0, (year / 10) % 10, year % 10);
          r.decimal_points = wmsc_pkg::PT3 | wmsc_pkg::PT4;
        end
        wmsc_pkg::MODE_EDIT_BRIGHT: begin
          // Saturate instead of wrapping
          if (op == wmsc_pkg::OP_UP) begin
            if (bright < wmsc_pkg::BRIGHT_MAX) bright = bright + 7'd1;
          end else if (op == wmsc_pkg::OP_DOWN) begin
            if (bright > wmsc_pkg::BRIGHT_MIN) bright = bright - 7'd1;
          end else if (op == wmsc_pkg::OP_BOTH_DOWN || op == wmsc_pkg::OP_BOTH_UP) begin
            cur_mode = wmsc_pkg::MODE_SHOW_BRIGHT;
          end
          r.display_digits = digits4(wmsc_pkg::BLANK, wmsc_pkg::BLANK, (bright / 10) % 10,
                                     bright % 10);
          r.decimal_points = wmsc_pkg::PT3 | wmsc_pkg::PT4;
        end
        default: begin
          r.display_digits = digits4(t.rtc_hour_bcd[5:4], t.rtc_hour_bcd[3:0],
                                     t.rtc_minute_bcd[6:4], t.rtc_minute_bcd[3:0]);
          r.decimal_points = t.blink_phase ? wmsc_pkg::PT2 : 4'b0000;
          if (op == wmsc_pkg::OP_UP) cur_mode = wmsc_pkg::MODE_SHOW_DATE;
          else if (op == wmsc_pkg::OP_DOWN) cur_mode = wmsc_pkg::MODE_SHOW_BAT;
          else if (op == wmsc_pkg::OP_BOTH_DOWN) begin
            cur_mode = wmsc_pkg::MODE_EDIT_HOURS;
            fetch_time(t);
          end else if (op == wmsc_pkg::OP_BOTH_UP) begin
            cur_mode = wmsc_pkg::MODE_EDIT_MINS;
            fetch_time(t);
          end else cur_mode = wmsc_pkg::MODE_SHOW_TIME;
        end
      endcase
      r.set_hours        = hours;
      r.set_minutes      = minutes;
      r.set_day          = day;
      r.set_month        = month;
      r.set_year         = year;
      r.brightness_level = bright;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
    endfunction

    function void check_result(wmsc_pkg::wmsc_result_t got);
      wmsc_pkg::wmsc_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result word with no tick pending");
        return;
      end
      want = expected_q.pop_front();
      compare_field("display_digits", want.display_digits, got.display_digits);
      compare_field("decimal_points", want.decimal_points, got.decimal_points);
      compare_field("write_time", want.write_time, got.write_time);
      compare_field("write_date", want.write_date, got.write_date);
      compare_field("set_hours", want.set_hours, got.set_hours);
      compare_field("set_minutes", want.set_minutes, got.set_minutes);
      compare_field("set_day", want.set_day, got.set_day);
      compare_field("set_month", want.set_month, got.set_month);
      compare_field("set_year", want.set_year, got.set_year);
      compare_field("brightness_level", want.brightness_level, got.brightness_level);
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic                   out_valid;
  logic                   out_stall;
  wmsc_pkg::wmsc_item_t   tick_word;
  wmsc_pkg::wmsc_result_t seen_word;
  logic [15:0]            display_digits;
  logic [3:0]             decimal_points;
  logic                   write_time;
  logic                   write_date;
  logic [4:0]             set_hours;
  logic [5:0]             set_minutes;
  logic [4:0]             set_day;
  logic [3:0]             set_month;
  logic [6:0]             set_year;
  logic [6:0]             brightness_level;

  watch_scoreboard sb;
  bit              steady;
  bit              run_up;
  int              exit_pct;
  int              cycle_count;

  assign seen_word = {display_digits, decimal_points, write_time, write_date, set_hours,
                      set_minutes, set_day, set_month, set_year, brightness_level};

  watch_mode_and_set_controller u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .blink_phase      (tick_word.blink_phase),
    .opcode           (tick_word.opcode),
    .rtc_hour_bcd     (tick_word.rtc_hour_bcd),
    .rtc_minute_bcd   (tick_word.rtc_minute_bcd),
    .rtc_day_bcd      (tick_word.rtc_day_bcd),
    .rtc_month_bcd    (tick_word.rtc_month_bcd),
    .rtc_year_bcd     (tick_word.rtc_year_bcd),
    .battery_percent  (tick_word.battery_percent),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .display_digits   (display_digits),
    .decimal_points   (decimal_points),
    .write_time       (write_time),
    .write_date       (write_date),
    .set_hours        (set_hours),
    .set_minutes      (set_minutes),
    .set_day          (set_day),
    .set_month        (set_month),
    .set_year         (set_year),
    .brightness_level (brightness_level)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Check every result word taken from the block
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(seen_word);
  end

  // Stall the result side a random number of cycles per word
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 5);
      repeat (hold) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
      @(negedge clk);
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Offer one tick word after a random gap and hold it until taken
  task automatic send_tick(input wmsc_pkg::wmsc_item_t t);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    tick_word = t;
    in_valid  = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(t);
    // Switch now and then between idling and back-to-back traffic
    if ($urandom_range(0, 99) < 3) steady = !steady;
  endtask

  task automatic send_fields(input logic blink, input logic [2:0] op, input logic [5:0] hr,
                             input logic [6:0] mi, input logic [5:0] dy, input logic [4:0] mo,
                             input logic [7:0] yr, input logic [6:0] bat);
    send_tick({blink, op, hr, mi, dy, mo, yr, bat});
  endtask

  // Half the time a well-formed BCD pair, otherwise any raw value
  function automatic int bcd_pick(int max_tens, int raw_max);
    if ($urandom_range(0, 1)) return $urandom_range(0, raw_max);
    return $urandom_range(0, max_tens) * 16 + $urandom_range(0, 9);
  endfunction

  // Pick buttons from the predicted mode: long up/down runs while editing
  task automatic random_tick();
    wmsc_pkg::wmsc_item_t t;
    int                   pick;
    pick = $urandom_range(0, 99);
    if (sb.cur_mode >= wmsc_pkg::MODE_EDIT_HOURS) begin
      if (pick < exit_pct) begin
        t.opcode = $urandom_range(0, 1) ? wmsc_pkg::OP_BOTH_DOWN : wmsc_pkg::OP_BOTH_UP;
      end else if (pick < exit_pct + 6) t.opcode = 3'($urandom_range(0, 7));
      else begin
        if ($urandom_range(0, 99) < 8) run_up = !run_up;
        t.opcode = run_up ? wmsc_pkg::OP_UP : wmsc_pkg::OP_DOWN;
      end
    end else begin
      case ($urandom_range(0, 2))
        0: exit_pct = 2;
        1: exit_pct = 10;
        default: exit_pct = 30;
      endcase
      t.opcode = (pick < 90)
                 ? 3'($urandom_range(wmsc_pkg::OP_NONE, wmsc_pkg::OP_BOTH_UP))
                 : 3'($urandom_range(OP_SPARE5, OP_SPARE7));
    end
    t.blink_phase     = 1'($urandom_range(0, 1));
    t.rtc_hour_bcd    = 6'(bcd_pick(2, 63));
    t.rtc_minute_bcd  = 7'(bcd_pick(5, 127));
    t.rtc_day_bcd     = 6'(bcd_pick(3, 63));
    t.rtc_month_bcd   = 5'(bcd_pick(1, 31));
    t.rtc_year_bcd    = 8'(bcd_pick(9, 255));
    t.battery_percent = 7'($urandom_range(0, 100));
    send_tick(t);
  endtask

  initial begin
    sb          = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    tick_word   = '0;
    steady      = 1'b0;
    run_up      = 1'b1;
    exit_pct    = 10;
    cycle_count = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Show time with blink, spare button codes, raw BCD above nine
    send_fields(1'b1, wmsc_pkg::OP_NONE, 6'h23, 7'h59, 6'h31, 5'h12, 8'h99, 7'd100);
    send_fields(1'b0, OP_SPARE5, 6'h3F, 7'h7F, 6'h3F, 5'h1F, 8'hFF, 7'd0);
    send_fields(1'b1, OP_SPARE7, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd64);
    send_fields(1'b0, OP_SPARE6, 6'h12, 7'h34, 6'h15, 5'h06, 8'h42, 7'd37);
    // Time edit: clamped load, wrap both ways, write on exit
    send_fields(1'b0, wmsc_pkg::OP_BOTH_DOWN, 6'h3F, 7'h7F, 6'h00, 5'h00, 8'h00, 7'd0);
    send_fields(1'b1, wmsc_pkg::OP_UP, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd0);
    send_fields(1'b0, wmsc_pkg::OP_DOWN, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd0);
    send_fields(1'b0, wmsc_pkg::OP_BOTH_DOWN, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd0);
    send_fields(1'b0, wmsc_pkg::OP_UP, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd0);
    send_fields(1'b0, wmsc_pkg::OP_BOTH_DOWN, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd0);
    // Date edit: zero day and month load as one, day wraps at 31
    send_fields(1'b0, wmsc_pkg::OP_UP, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd0);
    send_fields(1'b0, wmsc_pkg::OP_BOTH_DOWN, 6'h00, 7'h00, 6'h00, 5'h00, 8'hFF, 7'd0);
    send_fields(1'b0, wmsc_pkg::OP_DOWN, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd0);
    send_fields(1'b0, wmsc_pkg::OP_BOTH_DOWN, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd0);
    send_fields(1'b0, wmsc_pkg::OP_DOWN, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd0);
    send_fields(1'b0, wmsc_pkg::OP_BOTH_DOWN, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd0);
    send_fields(1'b0, wmsc_pkg::OP_BOTH_UP, 6'h00, 7'h00, 6'h3F, 5'h1F, 8'h00, 7'd0);
    send_fields(1'b0, wmsc_pkg::OP_BOTH_UP, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd0);
    send_fields(1'b0, wmsc_pkg::OP_BOTH_UP, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd0);
    // Year edit from the top of the range
    send_fields(1'b0, wmsc_pkg::OP_UP, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd0);
    send_fields(1'b0, wmsc_pkg::OP_BOTH_UP, 6'h00, 7'h00, 6'h00, 5'h00, 8'hFF, 7'd0);
    send_fields(1'b0, wmsc_pkg::OP_UP, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd0);
    send_fields(1'b0, wmsc_pkg::OP_BOTH_DOWN, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd0);
    // Walk down to battery, where both-button words are ignored
    send_fields(1'b0, wmsc_pkg::OP_DOWN, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd0);
    send_fields(1'b0, wmsc_pkg::OP_DOWN, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd0);
    send_fields(1'b0, wmsc_pkg::OP_DOWN, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd100);
    send_fields(1'b0, wmsc_pkg::OP_BOTH_DOWN, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd0);
    send_fields(1'b0, wmsc_pkg::OP_BOTH_UP, 6'h00, 7'h00, 6'h00, 5'h00, 8'h00, 7'd0);

    repeat (RANDOM_TICKS) random_tick();
    @(negedge clk);
    in_valid = 1'b0;

    // Drain outstanding words, then let the pipeline settle
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wmsc_pkg.sv
rtl/wmsc_step.sv
rtl/watch_mode_and_set_controller.sv
tb/tb_watch_mode_and_set_controller.sv
